>>> rtl/core/multiset_combination_generator_core_macros.svh
// Assertion macros used by the multiset combination generator RTL.
`ifndef MULTISET_COMBINATION_GENERATOR_CORE_MACROS_SVH
`define MULTISET_COMBINATION_GENERATOR_CORE_MACROS_SVH
`ifndef SYNTH
// Antecedent implies consequent in the same cycle.
`define MCG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mcg assertion failed");
// Antecedent implies consequent in the next cycle.
`define MCG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mcg assertion failed");
`else
`define MCG_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MCG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/mcg_pkg.sv
// Package with types and constants of the multiset combination generator.
package mcg_pkg;
	localparam int MAX_DISTINCT_DEF = 16;
	localparam int ID_BITS_DEF = 16;
	localparam int COUNT_BITS_DEF = 8;
	localparam int SIZE_W = 12;
	localparam int DIST_W = 5;
	localparam int IDX_W = 4;
	localparam int CMD_W = 2;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD = 2'd0,
		CMD_RESTART = 2'd1,
		CMD_NEXT = 2'd2,
		CMD_NOP = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SUBSET_SIZE = 2'd0,
		REG_DISTINCT = 2'd1,
		REG_REPORT = 2'd2,
		REG_NONE = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE, S_FP_RD, S_FP_WR, S_SC_RD, S_SC_CHK, S_RF_RD, S_RF_WR,
		S_EM_RD, S_EM_OUT, S_EM_END, S_EXH
	} state_t;

	typedef struct packed {
		logic [SIZE_W-1:0] subset_size;
		logic [DIST_W-1:0] distinct_count;
		logic report_outside;
		logic restart;
	} cfg_t;
endpackage

>>> rtl/core/mcg_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
module mcg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> rtl/core/mcg_seq.sv
// Sequencer that walks the entry and pick memories and emits result items.
`include "multiset_combination_generator_core_macros.svh"
module mcg_seq import mcg_pkg::*; #(
	parameter int MAX_DISTINCT = MAX_DISTINCT_DEF,
	parameter int ID_BITS = ID_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic in_valid,
	output logic in_ready,
	input logic [CMD_W-1:0] in_cmd,
	input logic [IDX_W-1:0] in_idx,
	input logic [ID_BITS-1:0] in_id,
	input logic [COUNT_BITS-1:0] in_mult,
	output logic out_valid,
	input logic out_ready,
	output logic [ID_BITS-1:0] out_element,
	output logic [COUNT_BITS-1:0] out_count,
	output logic [COUNT_BITS-1:0] out_leftover,
	output logic out_last,
	output logic out_exhausted
);
	localparam int AW = $clog2(MAX_DISTINCT);
	localparam int CW = $clog2(MAX_DISTINCT + 1);
	localparam int SA = COUNT_BITS + CW;
	localparam int SW = (SA > SIZE_W ? SA : SIZE_W) + 1;
	localparam int EW = ID_BITS + COUNT_BITS;

	state_t state_q, state_d;
	logic [CW-1:0] idx_q, idx_d, n;
	logic [SW-1:0] tail_q, tail_d, room_q, room_d;
	logic first_q, first_d, done_q, done_d;
	logic held_v_q, held_v_d;
	logic [ID_BITS-1:0] held_id_q, held_id_d;
	logic [COUNT_BITS-1:0] held_cnt_q, held_cnt_d, held_left_q, held_left_d;

	logic ent_we, ent_re, pick_we, pick_re;
	logic [AW-1:0] ent_waddr, mem_raddr, pick_waddr;
	logic [EW-1:0] ent_wdata, ent_rdata;
	logic [COUNT_BITS-1:0] pick_wdata, pick_rd, mult_rd, min_v;
	logic [ID_BITS-1:0] id_rd;
	logic out_free, push, push_last, push_exh;

	assign n = (32'(cfg.distinct_count) > MAX_DISTINCT) ? CW'(MAX_DISTINCT)
		: CW'(cfg.distinct_count);
	assign id_rd = ent_rdata[EW-1:COUNT_BITS];
	assign mult_rd = ent_rdata[COUNT_BITS-1:0];
	assign mem_raddr = idx_q[AW-1:0];
	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == S_IDLE);
	// Clamp the running total to an entry's multiplicity.
	assign min_v = (SW'(mult_rd) < tail_q) ? mult_rd : COUNT_BITS'(tail_q);

	mcg_ram #(.WIDTH(EW), .DEPTH(MAX_DISTINCT)) u_ent (
		.clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
		.re(ent_re), .raddr(mem_raddr), .rdata(ent_rdata)
	);
	mcg_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_DISTINCT)) u_pick (
		.clk(clk), .we(pick_we), .waddr(pick_waddr), .wdata(pick_wdata),
		.re(pick_re), .raddr(mem_raddr), .rdata(pick_rd)
	);

	// State and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			first_q <= 1'b1;
			done_q <= 1'b0;
			held_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			first_q <= first_d;
			done_q <= done_d;
			held_v_q <= held_v_d;
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		tail_q <= tail_d;
		room_q <= room_d;
		held_id_q <= held_id_d;
		held_cnt_q <= held_cnt_d;
		held_left_q <= held_left_d;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (push) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_element <= push_exh ? '0 : held_id_q;
			out_count <= push_exh ? '0 : held_cnt_q;
			out_leftover <= push_exh ? '0 : held_left_q;
			out_last <= push_last;
			out_exhausted <= push_exh;
		end
	end

	// Next state and memory controls.
	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		tail_d = tail_q;
		room_d = room_q;
		first_d = first_q;
		done_d = done_q;
		held_v_d = held_v_q;
		held_id_d = held_id_q;
		held_cnt_d = held_cnt_q;
		held_left_d = held_left_q;
		ent_we = 1'b0;
		ent_re = 1'b0;
		ent_waddr = AW'(in_idx);
		ent_wdata = {in_id, in_mult};
		pick_we = 1'b0;
		pick_re = 1'b0;
		pick_waddr = idx_q[AW-1:0];
		pick_wdata = min_v;
		push = 1'b0;
		push_last = 1'b0;
		push_exh = 1'b0;
		if (cfg.restart) begin
			first_d = 1'b1;
			done_d = 1'b0;
		end
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (cmd_t'(in_cmd))
						CMD_LOAD: begin
							ent_we = (32'(in_idx) < MAX_DISTINCT);
							first_d = 1'b1;
							done_d = 1'b0;
						end
						CMD_RESTART: begin
							first_d = 1'b1;
							done_d = 1'b0;
						end
						CMD_NEXT: begin
							if (done_q) begin
								state_d = S_EXH;
							end else if (first_q) begin
								first_d = 1'b0;
								idx_d = '0;
								tail_d = SW'(cfg.subset_size);
								state_d = S_FP_RD;
							end else if (n == '0) begin
								done_d = 1'b1;
								state_d = S_EXH;
							end else begin
								idx_d = n - 1'b1;
								tail_d = '0;
								room_d = '0;
								state_d = S_SC_RD;
							end
						end
						default: begin
						end
					endcase
				end
			end
			// First pick: fill greedily from the front.
			S_FP_RD: begin
				if (idx_q == n) begin
					held_v_d = 1'b0;
					idx_d = '0;
					if (tail_q == '0 && cfg.subset_size != '0) begin
						state_d = S_EM_RD;
					end else begin
						done_d = 1'b1;
						state_d = S_EXH;
					end
				end else begin
					ent_re = 1'b1;
					state_d = S_FP_WR;
				end
			end
			S_FP_WR: begin
				pick_we = 1'b1;
				tail_d = tail_q - SW'(min_v);
				idx_d = idx_q + 1'b1;
				state_d = S_FP_RD;
			end
			// Scan back for an entry that can give up one copy.
			S_SC_RD: begin
				ent_re = 1'b1;
				pick_re = 1'b1;
				state_d = S_SC_CHK;
			end
			S_SC_CHK: begin
				if (pick_rd != '0 && room_q >= tail_q + 1'b1) begin
					pick_we = 1'b1;
					pick_wdata = pick_rd - 1'b1;
					tail_d = tail_q + 1'b1;
					idx_d = idx_q + 1'b1;
					if (idx_q + 1'b1 == n) begin
						held_v_d = 1'b0;
						idx_d = '0;
						state_d = S_EM_RD;
					end else begin
						state_d = S_RF_RD;
					end
				end else begin
					tail_d = tail_q + SW'(pick_rd);
					room_d = room_q + SW'(mult_rd);
					if (idx_q == '0) begin
						done_d = 1'b1;
						state_d = S_EXH;
					end else begin
						idx_d = idx_q - 1'b1;
						state_d = S_SC_RD;
					end
				end
			end
			// Refill the entries after the decremented one.
			S_RF_RD: begin
				ent_re = 1'b1;
				state_d = S_RF_WR;
			end
			S_RF_WR: begin
				pick_we = 1'b1;
				tail_d = tail_q - SW'(min_v);
				idx_d = idx_q + 1'b1;
				if (idx_q + 1'b1 == n) begin
					held_v_d = 1'b0;
					idx_d = '0;
					state_d = S_EM_RD;
				end else begin
					state_d = S_RF_RD;
				end
			end
			// Emit nonzero entries, holding one back to mark the last.
			S_EM_RD: begin
				if (idx_q == n) begin
					state_d = S_EM_END;
				end else begin
					ent_re = 1'b1;
					pick_re = 1'b1;
					state_d = S_EM_OUT;
				end
			end
			S_EM_OUT: begin
				if (pick_rd == '0) begin
					idx_d = idx_q + 1'b1;
					state_d = S_EM_RD;
				end else if (!held_v_q || out_free) begin
					push = held_v_q;
					held_v_d = 1'b1;
					held_id_d = id_rd;
					held_cnt_d = pick_rd;
					held_left_d = cfg.report_outside ? mult_rd - pick_rd : '0;
					idx_d = idx_q + 1'b1;
					state_d = S_EM_RD;
				end
			end
			S_EM_END: begin
				if (!held_v_q) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					push = 1'b1;
					push_last = 1'b1;
					held_v_d = 1'b0;
					state_d = S_IDLE;
				end
			end
			S_EXH: begin
				if (out_free) begin
					push = 1'b1;
					push_exh = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`MCG_ASSERT_SAME(a_pick_wr_state, clk, arst_n, pick_we, (state_q == S_FP_WR || state_q == S_SC_CHK || state_q == S_RF_WR))
	`MCG_ASSERT_SAME(a_exh_clean, clk, arst_n, out_valid && out_exhausted, (out_element == '0 && out_count == '0 && !out_last))
	`MCG_ASSERT_SAME(a_end_has_item, clk, arst_n, state_q == S_EM_END, held_v_q)
	`MCG_ASSERT_NEXT(a_next_leaves_idle, clk, arst_n, in_valid && in_ready && in_cmd == CMD_NEXT, state_q != S_IDLE)
endmodule

>>> rtl/core/multiset_combination_generator_core.sv
// Operation: a next command steps the pick (scan back over the used entries, then
// refill the entries after the decremented one) and then reads each entry to emit it.
// Throughput: one command at a time; loads and restarts leave the sequencer idle.
// Stepping is paced by the single read port of each of the entry and pick memories.
// Reset: asynchronous, active low; registers return to 1, 1, 1; entries undefined.
module multiset_combination_generator_core import mcg_pkg::*; #(
	parameter int MAX_DISTINCT = MAX_DISTINCT_DEF,
	parameter int ID_BITS = ID_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF,
	localparam int IN_W = ((IDX_W + ID_BITS + COUNT_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((ID_BITS + 2 * COUNT_BITS + 7) / 8) * 8
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [SIZE_W-1:0] cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	// entry_index, element_id, multiplicity, zero fill
	input logic [IN_W-1:0] s_tdata,
	// command
	input logic [CMD_W-1:0] s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// out_element, out_count, leftover, zero fill
	output logic [OUT_W-1:0] m_tdata,
	// exhausted
	output logic m_tuser,
	output logic m_tlast
);
	cfg_t cfg;
	logic [SIZE_W-1:0] size_q;
	logic [DIST_W-1:0] dist_q;
	logic report_q, cfg_wr;
	logic [ID_BITS-1:0] o_id;
	logic [COUNT_BITS-1:0] o_cnt, o_left;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(1);
			dist_q <= DIST_W'(1);
			report_q <= 1'b1;
		end else if (cfg_wr) begin
			case (reg_idx_t'(cfg_index))
				REG_SUBSET_SIZE: size_q <= cfg_data;
				REG_DISTINCT: dist_q <= cfg_data[DIST_W-1:0];
				REG_REPORT: report_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// A size or entry count write restarts the enumeration.
	assign cfg.subset_size = size_q;
	assign cfg.distinct_count = dist_q;
	assign cfg.report_outside = report_q;
	assign cfg.restart = cfg_wr && (cfg_index == REG_SUBSET_SIZE || cfg_index == REG_DISTINCT);

	mcg_seq #(
		.MAX_DISTINCT(MAX_DISTINCT), .ID_BITS(ID_BITS), .COUNT_BITS(COUNT_BITS)
	) u_seq (
		.clk(clk), .arst_n(arst_n), .cfg(cfg),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_cmd(s_tuser),
		.in_idx(s_tdata[IDX_W-1:0]),
		.in_id(s_tdata[IDX_W+ID_BITS-1:IDX_W]),
		.in_mult(s_tdata[IDX_W+ID_BITS+COUNT_BITS-1:IDX_W+ID_BITS]),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_element(o_id), .out_count(o_cnt), .out_leftover(o_left),
		.out_last(m_tlast), .out_exhausted(m_tuser)
	);

	// Pack the result transaction.
	assign m_tdata = OUT_W'({o_left, o_cnt, o_id});
endmodule
